>>> rtl/core/msms_pkg.sv
// Shared types and constants for the minimum-separation mark store.
// Depends on nothing; imported by the controller, datapath and top level.
package msms_pkg;

   localparam int XY_W     = 16;
   localparam int THR_W    = 33;
   localparam int COLOR_W  = 24;
   localparam int RSP_CNT_W = 9;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_SEP_SQ = 2'd0,
      CSR_USE_PALETTE = 2'd1,
      CSR_FIXED_COLOR = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_STORED    = 2'd0,
      OUT_NONFINITE = 2'd1,
      OUT_DUPLICATE = 2'd2,
      OUT_FULL      = 2'd3
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;    // latch the point, clear the hit flag and scan index
      logic read;    // issue a table read at the scan index and advance
      logic finish;  // judge, store if allowed and emit the result
   } cmd_type;

   typedef struct packed {
      logic empty;      // no marks held
      logic scan_last;  // scan index points at the last held mark
      logic pipe_idle;  // no compare in flight
   } status_type;

   localparam logic [COLOR_W-1:0] RST_FIXED_COLOR = 24'h4287F5;
   localparam logic [THR_W-1:0]   RST_MIN_SEP_SQ  = 33'd4096;

   function automatic logic [COLOR_W-1:0] palette_color(input logic [2:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         3'd0:    c = 24'hE63946;
         3'd1:    c = 24'h1D3557;
         3'd2:    c = 24'h2A9D8F;
         3'd3:    c = 24'hE9C46A;
         3'd4:    c = 24'hF4A261;
         3'd5:    c = 24'h7E57C2;
         3'd6:    c = 24'h457B9D;
         default: c = 24'hE76F51;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/core/msms_ctrl.sv
// Sequencing state machine of the mark store: accept, scan, drain, finish.
// Depends on msms_pkg for the state, command and status types.
module msms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                coords_finite,
   input  msms_pkg::status_type status,
   output msms_pkg::cmd_type   cmd,
   output logic                busy
);
   import msms_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               // non-finite point or nothing to compare against: judge at once
               if (coords_finite && !status.empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_idle) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> rtl/core/msms_datapath.sv
// Mark table, configuration registers, distance pipeline and result registers.
// Depends on msms_pkg for types, codes, reset values and the palette.
module msms_datapath #(
   parameter int MAX_MARKS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  msms_pkg::cmd_type                    cmd,
   output msms_pkg::status_type                 status,
   input  logic signed [msms_pkg::XY_W-1:0]     req_x_pos,
   input  logic signed [msms_pkg::XY_W-1:0]     req_y_pos,
   input  logic                                 req_coords_finite,
   input  logic                                 csr_we,
   input  logic [msms_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msms_pkg::THR_W-1:0]           csr_wdata,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_outcome,
   output logic [msms_pkg::RSP_CNT_W-1:0]       rsp_mark_number,
   output logic [msms_pkg::RSP_CNT_W-1:0]       rsp_mark_count,
   output logic [msms_pkg::COLOR_W-1:0]         rsp_mark_color
);
   import msms_pkg::*;

   localparam int CW = $clog2(MAX_MARKS + 1);
   localparam int AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
   localparam int SQ_W = 2 * XY_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_MARKS);

   // configuration
   logic [THR_W-1:0]   min_sep_ff;
   logic               use_palette_ff;
   logic [COLOR_W-1:0] fixed_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_sep_ff     <= RST_MIN_SEP_SQ;
         use_palette_ff <= 1'b0;
         fixed_color_ff <= RST_FIXED_COLOR;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_SEP_SQ:  min_sep_ff     <= csr_wdata;
            CSR_USE_PALETTE: use_palette_ff <= csr_wdata[0];
            CSR_FIXED_COLOR: fixed_color_ff <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // held item
   logic signed [XY_W-1:0] x_ff, y_ff;
   logic                   finite_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff      <= req_x_pos;
         y_ff      <= req_y_pos;
         finite_ff <= req_coords_finite;
      end
   end

   // mark table: x in the low half, y in the high half
   logic [2*XY_W-1:0] mem [MAX_MARKS];
   logic [2*XY_W-1:0] rd_data_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     scan_idx_ff;
   logic              wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= {y_ff, x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[scan_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_idx_ff <= '0;
      end else if (cmd.read) begin
         scan_idx_ff <= scan_idx_ff + CW'(1);
      end
   end

   // squared distance: subtract and square, then add and compare
   logic              rd_v_ff, sq_v_ff, hit_ff;
   logic signed [XY_W:0] dx, dy, ndx, ndy;
   logic [XY_W-1:0]   adx, ady;
   logic [2*XY_W-1:0] sqx_ff, sqy_ff;
   logic [THR_W-1:0]  dist_sq;

   always_comb begin
      dx  = {rd_data_ff[XY_W-1], rd_data_ff[XY_W-1:0]} - {x_ff[XY_W-1], x_ff};
      dy  = {rd_data_ff[2*XY_W-1], rd_data_ff[2*XY_W-1:XY_W]} - {y_ff[XY_W-1], y_ff};
      ndx = -dx;
      ndy = -dy;
      adx = dx[XY_W] ? ndx[XY_W-1:0] : dx[XY_W-1:0];
      ady = dy[XY_W] ? ndy[XY_W-1:0] : dy[XY_W-1:0];
      dist_sq = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         sqx_ff <= SQ_W'(adx) * SQ_W'(adx);
         sqy_ff <= SQ_W'(ady) * SQ_W'(ady);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         sq_v_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         rd_v_ff <= cmd.read;
         sq_v_ff <= rd_v_ff;
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (sq_v_ff && (dist_sq <= min_sep_ff)) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // judgement
   logic [1:0]         outcome;
   logic [COLOR_W-1:0] color;
   logic [CW+2:0]      count_pal;
   logic [CW+RSP_CNT_W-1:0] num_ext, cnt_ext;

   always_comb begin
      count_pal = {3'b000, count_ff};
      wr_en     = 1'b0;
      count_in  = count_ff;
      color     = '0;
      if (!finite_ff) begin
         outcome = OUT_NONFINITE;
      end else if (hit_ff) begin
         outcome = OUT_DUPLICATE;
      end else if (count_ff >= FULL_COUNT) begin
         outcome = OUT_FULL;
      end else begin
         outcome  = OUT_STORED;
         wr_en    = cmd.finish;
         count_in = count_ff + CW'(1);
         color    = use_palette_ff ? palette_color(count_pal[2:0]) : fixed_color_ff;
      end
      num_ext = (outcome == OUT_STORED) ? {{RSP_CNT_W{1'b0}}, count_in} : '0;
      cnt_ext = {{RSP_CNT_W{1'b0}}, count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.finish;
         if (cmd.finish) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_outcome     <= outcome;
         rsp_mark_number <= num_ext[RSP_CNT_W-1:0];
         rsp_mark_count  <= cnt_ext[RSP_CNT_W-1:0];
         rsp_mark_color  <= color;
      end
   end

   assign status.empty     = (count_ff == '0);
   assign status.scan_last = ((scan_idx_ff + CW'(1)) == count_ff);
   assign status.pipe_idle = !rd_v_ff && !sq_v_ff;

endmodule

>>> rtl/core/min_separation_mark_store_top.sv
// Top level of the minimum-separation mark store.
// Depends on msms_pkg, msms_ctrl and msms_datapath.
//
// Usage:
//   Input: drive req_x_pos, req_y_pos, req_coords_finite and raise start;
//   the item is taken at the edge where start is high and busy is low.
//   Output: one result per item, shown for exactly one cycle with rsp_valid
//   high. The receiver cannot stall; it must take the result in that cycle.
//   Configuration: csr_valid/csr_ready with csr_index and csr_wdata; a write
//   lands when both are high. csr_ready is high while the block is idle.
//   Indexes: 0 squared minimum separation, 1 palette select, 2 fixed colour.
// Timing:
//   A point with held marks to compare against is scanned, the compare
//   pipeline is drained and the result is judged; a non-finite point or an
//   empty table goes straight to the judgement. The table is scanned one
//   mark per cycle through its single read port. busy falls in the
//   cycle that rsp_valid is shown, and the next item may start then.
// Reset:
//   Synchronous, active high. Clears the mark count and the configuration
//   to its defaults; table contents are left as they are and never read
//   above the count, so no clearing pass is needed.
module min_separation_mark_store_top #(
   parameter int MAX_MARKS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [msms_pkg::XY_W-1:0]     req_x_pos,
   input  logic signed [msms_pkg::XY_W-1:0]     req_y_pos,
   input  logic                                 req_coords_finite,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_outcome,
   output logic [msms_pkg::RSP_CNT_W-1:0]       rsp_mark_number,
   output logic [msms_pkg::RSP_CNT_W-1:0]       rsp_mark_count,
   output logic [msms_pkg::COLOR_W-1:0]         rsp_mark_color,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msms_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msms_pkg::THR_W-1:0]           csr_wdata
);
   import msms_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_we;

   // take configuration only between items
   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   msms_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .coords_finite (req_coords_finite),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   msms_datapath #(
      .MAX_MARKS (MAX_MARKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_x_pos         (req_x_pos),
      .req_y_pos         (req_y_pos),
      .req_coords_finite (req_coords_finite),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_outcome       (rsp_outcome),
      .rsp_mark_number   (rsp_mark_number),
      .rsp_mark_count    (rsp_mark_count),
      .rsp_mark_color    (rsp_mark_color)
   );

   // an accepted item makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item accepted but block not busy");

   // the block only goes idle as it shows a result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("block went idle without a result");

   // a stored mark is always the newest one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_STORED) |-> rsp_mark_number == rsp_mark_count)
      else $error("stored mark number differs from mark count");

   // a dropped point reports no number and no colour
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome != OUT_STORED)
         |-> (rsp_mark_number == '0) && (rsp_mark_color == '0))
      else $error("dropped point carries a mark number or colour");

endmodule
